FILE: src/bn12_pkg.sv
// shared types and constants for the bgra to nv12 converter
// no dependencies; used by bn12_front, bn12_back and the top level under src
package bn12_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int FW_W          = 13;
  localparam logic [FW_W-1:0] WIDTH_RESET = 13'd1920;

  // queue depths between front and back, and on the result side
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // bt.601 limited range coefficients
  localparam logic [15:0] Y_R    = 16'd66;
  localparam logic [15:0] Y_G    = 16'd129;
  localparam logic [15:0] Y_B    = 16'd25;
  localparam logic [15:0] RND    = 16'd128;
  localparam logic [7:0]  Y_OFS  = 8'd16;
  localparam logic [15:0] CB_R   = 16'd38;
  localparam logic [15:0] CB_G   = 16'd74;
  localparam logic [15:0] C_BLUE = 16'd112;
  localparam logic [15:0] CR_G   = 16'd94;
  localparam logic [15:0] CR_B   = 16'd18;
  // rounding plus 128 << 8 so the sums stay non-negative
  localparam logic [15:0] C_BIAS = 16'd32896;

  typedef enum logic [1:0] {
    OP_LUMA_ONLY,
    OP_STORE_PAIR,
    OP_CHROMA
  } op_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } sum9_t;

  typedef struct packed {
    op_t   op;
    rgb_t  rgb;
    sum9_t pair;
  } work_t;

endpackage

FILE: src/bn12_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module bn12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bn12_fifo.sv
// generic first-word-fall-through queue built from registers
// no dependencies
module bn12_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    level;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (level == CW'(DEPTH));
  assign empty   = (level == '0);
  assign count   = level;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      level <= level + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: src/bn12_front.sv
// front end: width register, column and row tracking, pixel pairing and
// classification of each pixel into a work request; uses bn12_pkg
module bn12_front #(
  parameter int MAX_WIDTH = bn12_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bn12_pkg::FW_W-1:0]     wr_data,
  input  logic                          push,
  input  bn12_pkg::pixel_in_t           pixel,
  output logic                          full,
  input  logic                          q_full,
  output logic                          q_push,
  output bn12_pkg::work_t               work,
  output logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] slot
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);
  localparam int EW          = bn12_pkg::FW_W + 1;
  localparam logic [EW-1:0] MAX_EXT  = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MAX_EVEN = MAX_EXT & ~EW'(1);

  logic [bn12_pkg::FW_W-1:0] frame_width;
  logic [CNT_W-1:0]          column_count;
  logic                      row_is_odd;
  bn12_pkg::rgb_t            held_pixel;

  logic [EW-1:0]    w_even;
  logic [EW-1:0]    w_clamp;
  logic [WID_W-1:0] eff_width;
  logic [CNT_W-1:0] col_cur;
  logic             odd_cur;
  logic [WID_W-1:0] cnt_inc;
  logic             row_end;
  bn12_pkg::rgb_t   rgb_cur;
  logic             accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  // effective row length: even, clamped to 2..max
  always_comb begin
    w_even = {1'b0, frame_width} & ~EW'(1);
    if (w_even < EW'(2)) begin
      w_clamp = EW'(2);
    end else if (w_even > MAX_EXT) begin
      w_clamp = MAX_EVEN;
    end else begin
      w_clamp = w_even;
    end
    eff_width = WID_W'(w_clamp);
  end

  always_comb begin
    col_cur   = pixel.frame_start ? '0 : column_count;
    odd_cur   = pixel.frame_start ? 1'b0 : row_is_odd;
    rgb_cur.r = pixel.pixel_word[23:16];
    rgb_cur.g = pixel.pixel_word[15:8];
    rgb_cur.b = pixel.pixel_word[7:0];
    cnt_inc   = WID_W'(col_cur) + WID_W'(1);
    row_end   = (cnt_inc >= eff_width);

    work.rgb    = rgb_cur;
    work.pair.r = 9'(held_pixel.r) + 9'(rgb_cur.r);
    work.pair.g = 9'(held_pixel.g) + 9'(rgb_cur.g);
    work.pair.b = 9'(held_pixel.b) + 9'(rgb_cur.b);
    if (!col_cur[0]) begin
      work.op = bn12_pkg::OP_LUMA_ONLY;
    end else if (odd_cur) begin
      work.op = bn12_pkg::OP_CHROMA;
    end else begin
      work.op = bn12_pkg::OP_STORE_PAIR;
    end
    slot = SLOT_W'(col_cur >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bn12_pkg::WIDTH_RESET;
      column_count <= '0;
      row_is_odd   <= 1'b0;
      held_pixel   <= '0;
    end else begin
      if (wr_en) begin
        frame_width <= wr_data;
      end
      if (accept) begin
        if (!col_cur[0]) begin
          held_pixel <= rgb_cur;
        end
        if (row_end) begin
          column_count <= '0;
          row_is_odd   <= !odd_cur;
        end else begin
          column_count <= CNT_W'(cnt_inc);
          row_is_odd   <= odd_cur;
        end
      end
    end
  end

endmodule

FILE: src/bn12_back.sv
// back end: line store access, luma and chroma arithmetic pipeline and
// result queue; uses bn12_pkg, bn12_ram and bn12_fifo
module bn12_back #(
  parameter int MAX_WIDTH = bn12_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 work_avail,
  input  bn12_pkg::work_t      work,
  input  logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] slot,
  output logic                 take,
  input  logic                 pop,
  output logic                 empty,
  output bn12_pkg::pixel_out_t result
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int OCW         = $clog2(bn12_pkg::OUT_DEPTH + 1);

  // stage 1: store data back, luma and block averages
  logic           s1_v;
  logic           s1_chroma;
  bn12_pkg::rgb_t s1_rgb;
  bn12_pkg::sum9_t s1_pair;
  // stage 2: chroma products
  logic           s2_v;
  logic           s2_chroma;
  logic [7:0]     s2_luma;
  bn12_pkg::rgb_t s2_avg;
  // stage 3: finished result
  logic                 s3_v;
  bn12_pkg::pixel_out_t s3_res;

  logic [$bits(bn12_pkg::sum9_t)-1:0] store_rdata;
  bn12_pkg::sum9_t store_entry;
  logic            store_we;
  logic [OCW-1:0]  out_count;
  logic [OCW:0]    committed;
  logic [15:0]     y_sum;
  logic [9:0]      r_tot;
  logic [9:0]      g_tot;
  logic [9:0]      b_tot;
  logic [15:0]     cb_sum;
  logic [15:0]     cr_sum;
  logic            out_full;

  // issue only when the result queue has room for everything in flight
  assign committed = (OCW + 1)'(out_count) + (OCW + 1)'(s1_v) + (OCW + 1)'(s2_v)
                     + (OCW + 1)'(s3_v);
  assign take      = work_avail && (committed < (OCW + 1)'(bn12_pkg::OUT_DEPTH));
  assign store_we  = take && (work.op == bn12_pkg::OP_STORE_PAIR);

  bn12_ram #(
    .WIDTH ($bits(bn12_pkg::sum9_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (slot),
    .wdata (work.pair),
    .raddr (slot),
    .rdata (store_rdata)
  );

  assign store_entry = bn12_pkg::sum9_t'(store_rdata);

  always_comb begin
    y_sum = bn12_pkg::Y_R * 16'(s1_rgb.r) + bn12_pkg::Y_G * 16'(s1_rgb.g)
            + bn12_pkg::Y_B * 16'(s1_rgb.b) + bn12_pkg::RND;
    r_tot = 10'(s1_pair.r) + 10'(store_entry.r);
    g_tot = 10'(s1_pair.g) + 10'(store_entry.g);
    b_tot = 10'(s1_pair.b) + 10'(store_entry.b);
  end

  // sums stay in 0..61456, so 16-bit wraparound arithmetic is exact
  always_comb begin
    cb_sum = bn12_pkg::C_BLUE * 16'(s2_avg.b) + bn12_pkg::C_BIAS
             - bn12_pkg::CB_R * 16'(s2_avg.r) - bn12_pkg::CB_G * 16'(s2_avg.g);
    cr_sum = bn12_pkg::C_BLUE * 16'(s2_avg.r) + bn12_pkg::C_BIAS
             - bn12_pkg::CR_G * 16'(s2_avg.g) - bn12_pkg::CR_B * 16'(s2_avg.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= take;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_chroma <= (work.op == bn12_pkg::OP_CHROMA);
    s1_rgb    <= work.rgb;
    s1_pair   <= work.pair;

    s2_chroma <= s1_chroma;
    s2_luma   <= y_sum[15:8] + bn12_pkg::Y_OFS;
    s2_avg.r  <= r_tot[9:2];
    s2_avg.g  <= g_tot[9:2];
    s2_avg.b  <= b_tot[9:2];

    s3_res.luma         <= s2_luma;
    s3_res.chroma_valid <= s2_chroma;
    s3_res.cb           <= s2_chroma ? cb_sum[15:8] : 8'd0;
    s3_res.cr           <= s2_chroma ? cr_sum[15:8] : 8'd0;
  end

  bn12_fifo #(
    .WIDTH ($bits(bn12_pkg::pixel_out_t)),
    .DEPTH (bn12_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s3_v),
    .wdata (s3_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

  // credit check keeps the result queue from overflowing
  assert property (@(posedge clk) disable iff (rst) s3_v |-> !out_full)
    else $error("result queue overflow");

endmodule

FILE: src/bgra_to_nv12_converter.sv
// top level of the bgra to nv12 converter: front end, work queue, back end
// uses bn12_pkg, bn12_front, bn12_fifo and bn12_back
//
//  channel   handshake          payload                 notes
//  pixel     push / full        bn12_pkg::pixel_in_t    raster order bgra
//  result    pop / empty        bn12_pkg::pixel_out_t   one per pixel, oldest first
//  config    wr_en              wr_data (frame width)   written while idle
//
// one pixel per clock sustained while the result side keeps popping; from accept
// to result a pixel passes work queue entry, store read, luma and averages, chroma products.
// synchronous reset clears counters, queues and sets frame width to 1920;
// the line store is not cleared. a stalled result side fills the result
// queue, then the work queue, then raises full.
module bgra_to_nv12_converter #(
  parameter int MAX_WIDTH = bn12_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [bn12_pkg::FW_W-1:0] wr_data,
  input  logic                      push,
  input  bn12_pkg::pixel_in_t       pixel,
  output logic                      full,
  input  logic                      pop,
  output logic                      empty,
  output bn12_pkg::pixel_out_t      result
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QW          = $bits(bn12_pkg::work_t) + SLOT_W;

  logic            mid_full;
  logic            mid_empty;
  logic            mid_push;
  logic            mid_pop;
  bn12_pkg::work_t work_f;
  bn12_pkg::work_t work_b;
  logic [SLOT_W-1:0] slot_f;
  logic [SLOT_W-1:0] slot_b;
  logic [QW-1:0]   mid_rdata;

  bn12_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .push    (push),
    .pixel   (pixel),
    .full    (full),
    .q_full  (mid_full),
    .q_push  (mid_push),
    .work    (work_f),
    .slot    (slot_f)
  );

  bn12_fifo #(
    .WIDTH (QW),
    .DEPTH (bn12_pkg::MID_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata ({work_f, slot_f}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count ()
  );

  assign {work_b, slot_b} = mid_rdata;

  bn12_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_avail (!mid_empty),
    .work       (work_b),
    .slot       (slot_b),
    .take       (mid_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  // nothing waits right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> empty)
    else $error("result present after reset");

  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.luma >= 8'd16) && (result.luma <= 8'd235))
    else $error("luma out of limited range");

  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.chroma_valid) |->
      (result.cb >= 8'd16) && (result.cb <= 8'd240)
      && (result.cr >= 8'd16) && (result.cr <= 8'd240))
    else $error("chroma out of limited range");

  assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.chroma_valid) |-> (result.cb == 8'd0) && (result.cr == 8'd0))
    else $error("chroma not zero without a finished block");

endmodule

FILE: test/tb_bgra_to_nv12_converter.sv
// testbench for bgra_to_nv12_converter: directed and random pixel streams over many
// frame widths, each result checked against a predictor of luma and 2x2 chroma
// depends on bn12_pkg and the converter rtl under src
module tb_bgra_to_nv12_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int STORE_SLOTS     = bn12_pkg::MAX_WIDTH_DEF / 2;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_PERCENT    = 22;

  class nv12_predictor;
    logic [bn12_pkg::FW_W-1:0] frame_width;
    bn12_pkg::rgb_t            held;
    bn12_pkg::sum9_t           pair_sums[STORE_SLOTS];
    bit                        pair_written[STORE_SLOTS];
    int                        column;
    bit                        odd_row;
    bn12_pkg::pixel_out_t      expected_pixels[$];
    int                        errors;

    function new();
      frame_width = bn12_pkg::WIDTH_RESET;
      held = '0;
      column = 0;
      odd_row = 0;
      errors = 0;
      foreach (pair_written[i]) pair_written[i] = 0;
    endfunction

    function int row_width();
      int w;
      w = int'(frame_width) & ~1;
      if (w < 2) w = 2;
      if (w > bn12_pkg::MAX_WIDTH_DEF) w = bn12_pkg::MAX_WIDTH_DEF;
      return w;
    endfunction

    // next pixel would close a block whose upper pair was never stored
    function bit blank_read();
      return (column % 2 == 1) && odd_row && !pair_written[column / 2];
    endfunction

    function bit row_start();
      return column == 0 && !odd_row;
    endfunction

    function void note_pixel(bn12_pkg::pixel_in_t item);
      bn12_pkg::rgb_t       px;
      bn12_pkg::sum9_t      pair;
      int                   ra, ga, ba, slot;
      bn12_pkg::pixel_out_t want;
      px = item.pixel_word[23:0];
      want = '0;
      if (item.frame_start) begin
        column = 0;
        odd_row = 0;
      end
      if (column % 2 == 0) begin
        held = px;
      end else begin
        pair.r = held.r + px.r;
        pair.g = held.g + px.g;
        pair.b = held.b + px.b;
        slot = column / 2;
        if (!odd_row) begin
          pair_sums[slot] = pair;
          pair_written[slot] = 1;
        end else begin
          ra = (int'(pair.r) + int'(pair_sums[slot].r)) >> 2;
          ga = (int'(pair.g) + int'(pair_sums[slot].g)) >> 2;
          ba = (int'(pair.b) + int'(pair_sums[slot].b)) >> 2;
          // the 128 << 8 offset keeps both sums positive before the shift
          want.chroma_valid = 1'b1;
          want.cb = 8'((112 * ba + 128 + 32768 - 38 * ra - 74 * ga) >> 8);
          want.cr = 8'((112 * ra + 128 + 32768 - 94 * ga - 18 * ba) >> 8);
        end
      end
      want.luma = 8'(((66 * int'(px.r) + 129 * int'(px.g) + 25 * int'(px.b) + 128) >> 8) + 16);
      column++;
      if (column >= row_width()) begin
        column = 0;
        odd_row = !odd_row;
      end
      expected_pixels.push_back(want);
    endfunction

    function void check_pixel(bn12_pkg::pixel_out_t got);
      bn12_pkg::pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: luma %0d cb %0d cr %0d",
               got.luma, got.cb, got.cr);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.luma !== want.luma) begin
        $error("luma: expected %0d, got %0d", want.luma, got.luma);
        errors++;
      end
      if (got.chroma_valid !== want.chroma_valid) begin
        $error("chroma_valid: expected %0d, got %0d", want.chroma_valid, got.chroma_valid);
        errors++;
      end
      if (got.cb !== want.cb) begin
        $error("cb: expected %0d, got %0d", want.cb, got.cb);
        errors++;
      end
      if (got.cr !== want.cr) begin
        $error("cr: expected %0d, got %0d", want.cr, got.cr);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      wr_en = 1'b0;
  logic [bn12_pkg::FW_W-1:0] wr_data = '0;
  logic                      push = 1'b0;
  bn12_pkg::pixel_in_t       pixel = '0;
  logic                      full;
  logic                      pop = 1'b0;
  logic                      empty;
  bn12_pkg::pixel_out_t      result;

  nv12_predictor board = new();
  bit            gaps_on = 1;
  bit            hold_request = 0;
  int            quiet_cycles = 0;

  bgra_to_nv12_converter #(
    .MAX_WIDTH(bn12_pkg::MAX_WIDTH_DEF)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .push   (push),
    .pixel  (pixel),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ends the run when neither side has moved a request for too long
  // handshakes are sampled mid-cycle, where they are settled for the next edge
  always @(negedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_side
    int                   hold_left;
    bit                   fire;
    bn12_pkg::pixel_out_t got;
    hold_left = 0;
    forever begin
      @(negedge clk);
      fire = !rst && pop && !empty;
      got = result;
      @(posedge clk);
      if (fire) board.check_pixel(got);
      if (hold_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(7) == 0)
      for (int i = 0; i < 4; i++) w[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    return w;
  endfunction

  task automatic send_pixel(input logic [31:0] word, input bit fs);
    bn12_pkg::pixel_in_t item;
    bit                  took;
    item.pixel_word = word;
    // restart the frame rather than close a block on an empty line store slot
    item.frame_start = fs || board.blank_read();
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel <= item;
    do begin
      @(negedge clk);
      took = !full;
      @(posedge clk);
    end while (!took);
    board.note_pixel(item);
  endtask

  task automatic write_frame_width(input logic [bn12_pkg::FW_W-1:0] value);
    push <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wr_en <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    board.frame_width = value;
  endtask

  // mostly whole frames, with a few frame starts dropped in mid-row
  task automatic stream_pixels(input int count);
    bit fs;
    repeat (count) begin
      fs = (board.row_start() && $urandom_range(3) == 0) || $urandom_range(199) < 3;
      send_pixel(random_word(), fs);
    end
  endtask

  initial begin : stimulus
    logic [31:0] corners[5] = '{32'hFFFFFFFF, 32'h00000000, 32'h00FF0000,
                                32'h0000FF00, 32'h000000FF};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero clamps to two-pixel rows, so every four pixels close a block
    write_frame_width('0);
    foreach (corners[k])
      for (int j = 0; j < 4; j++) send_pixel(corners[k], j == 0);
    // frame start on the odd column drops the partial row
    send_pixel(32'h12345678, 1'b1);
    send_pixel(32'h80C0E0F0, 1'b1);
    send_pixel(32'h80C0E0F0, 1'b0);
    send_pixel(32'h00FF80FF, 1'b0);
    send_pixel(32'hA01F3C7E, 1'b0);

    write_frame_width(13'd1);
    stream_pixels(120);
    write_frame_width(13'd4);
    stream_pixels(200);
    write_frame_width(13'd3);
    stream_pixels(120);

    gaps_on = 0;
    write_frame_width(13'd16);
    stream_pixels(200);
    gaps_on = 1;

    // long result stall while pixels keep coming
    write_frame_width(13'd62);
    hold_request = 1;
    stream_pixels(250);

    write_frame_width(13'd8191);
    stream_pixels(150);
    write_frame_width(13'd4096);
    stream_pixels(150);
    // shrink mid-row: the current row ends after the next pixel
    write_frame_width(13'd8);
    stream_pixels(150);
    write_frame_width(13'd4097);
    stream_pixels(60);
    write_frame_width(13'd6);
    stream_pixels(200);
    write_frame_width(13'd2);
    stream_pixels(100);

    push <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
